/* rtl/sadf_pkg.sv */
package sadf_pkg;

    localparam int CMD_W     = 2;
    localparam int REQ_W     = 24;
    localparam int HANDLE_W  = 16;
    localparam int SIZE_W    = 17;
    localparam int LARGE_W   = 25;
    localparam int SZ_W      = 25;
    localparam int OVF_W     = 25;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0]  START_RESET = SIZE_W'(16384);
    localparam logic [SIZE_W-1:0]  MAX_RESET   = SIZE_W'(65536);
    localparam logic [LARGE_W-1:0] LARGE_RESET = LARGE_W'(1048576);
    localparam logic [OVF_W-1:0]   OVF_MAX     = {OVF_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_RESIZE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_ROOM    = 2'd1,
        STAT_NOT_TOP    = 2'd2,
        STAT_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_SIZE = 2'd0,
        CFG_MAX_SIZE   = 2'd1,
        CFG_RESIZE_EN  = 2'd2,
        CFG_LARGE      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_WALK,
        ST_FIN
    } state_t;

endpackage

/* rtl/sadf_req_if.sv */
interface sadf_req_if;
    import sadf_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [REQ_W-1:0]    req_bytes;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, cmd, req_bytes, handle, input ready);
    modport sink (input valid, cmd, req_bytes, handle, output ready);
endinterface

/* rtl/sadf_rsp_if.sv */
interface sadf_rsp_if;
    import sadf_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [HANDLE_W-1:0] block_offset;
    logic [SIZE_W-1:0]   used_bytes;
    logic [SIZE_W-1:0]   capacity_bytes;
    logic                grew;

    modport source (output valid, status, block_offset, used_bytes, capacity_bytes, grew,
                    input ready);
    modport sink (input valid, status, block_offset, used_bytes, capacity_bytes, grew,
                  output ready);
endinterface

/* rtl/sadf_meta_mem.sv */
module sadf_meta_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int META_W = 16,
    parameter int LINK_W = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              meta_we,
    input  logic [ADDR_W-1:0] meta_waddr,
    input  logic [META_W-1:0] meta_wdata,
    input  logic              link_we,
    input  logic [ADDR_W-1:0] link_waddr,
    input  logic [LINK_W-1:0] link_wdata,
    output logic [META_W-1:0] rd_meta,
    output logic [LINK_W-1:0] rd_link,
    output logic              clr_busy
);

    logic [META_W-1:0] meta_mem [DEPTH];
    logic [LINK_W-1:0] link_mem [DEPTH];

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;

    // After reset every slot's marks are swept to zero, one slot a cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            meta_mem[cnt_reg] <= '0;
        end
        else if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        rd_meta <= meta_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        rd_link <= link_mem[rd_addr];
    end

    assign clr_busy = busy_reg;

endmodule

/* rtl/stack_allocator_deferred_free_unit.sv */
// Channel | Dir | Payload                                              | Handshake
// req     | in  | cmd, req_bytes, handle                               | valid/ready
// rsp     | out | status, block_offset, used_bytes, capacity_bytes, grew | valid/ready
// cfg     | in  | cfg_index, cfg_data                                  | cfg_we only
//
// An alloc, an unused command, or a free or resize whose handle is misaligned or at or
// above the top goes from EXEC to FIN; any other free or resize goes EXEC, CHECK, then
// WALK for each earlier freed block rolled back, then FIN. FIN loads the result once the
// output register is free; the next request is taken once it loads, even while it waits,
// and a later result waits for it to drain. After reset the block marks of all
// CAPACITY_BYTES/8 slots (8192 default) are cleared one slot a cycle; no request is taken.
module stack_allocator_deferred_free_unit #(
    parameter int CAPACITY_BYTES = 65536,
    parameter int HEADER_BYTES   = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sadf_req_if.sink                          req,
    sadf_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [sadf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sadf_pkg::CFG_W-1:0]        cfg_data
);
    import sadf_pkg::*;

    localparam int NSLOTS = CAPACITY_BYTES / 8;
    localparam int SLOT_W = $clog2(NSLOTS);
    localparam int LEN_W  = $clog2(NSLOTS + 1);
    localparam int TOP_W  = $clog2(CAPACITY_BYTES + 1);
    localparam int HW     = (TOP_W > HANDLE_W) ? TOP_W + 1 : HANDLE_W + 1;
    localparam int CW     = (HW > SZ_W) ? HW + 1 : SZ_W + 1;
    localparam int META_W = LEN_W + 2;

    typedef struct packed {
        logic             live;
        logic             deleted;
        logic [LEN_W-1:0] length;
    } meta_t;

    function automatic logic [TOP_W-1:0] clamp_cap(input logic [SIZE_W-1:0] v);
        int unsigned t;
        t = int'({v[SIZE_W-1:3], 3'b000});
        if (t < 8)
        begin
            t = 8;
        end
        if (t > CAPACITY_BYTES)
        begin
            t = CAPACITY_BYTES;
        end
        return TOP_W'(t);
    endfunction

    localparam logic [TOP_W-1:0] CAP_RESET = clamp_cap(START_RESET);

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [REQ_W-1:0]     reqb_reg, reqb_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [TOP_W-1:0]     top_reg, top_next;
    logic [TOP_W-1:0]     cap_reg, cap_next;
    logic [SIZE_W-1:0]    max_reg, max_next;
    logic                 resize_en_reg, resize_en_next;
    logic [LARGE_W-1:0]   large_reg, large_next;
    logic [OVF_W-1:0]     ovf_reg, ovf_next;
    logic [CNT_W-1:0]     incr_reg, incr_next;
    logic [SLOT_W-1:0]    cur_reg, cur_next;
    logic [SLOT_W-1:0]    lk_reg, lk_next;
    status_t              status_reg, status_next;
    logic [HANDLE_W-1:0]  boff_reg, boff_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [HANDLE_W-1:0]  out_boff_reg, out_boff_next;
    logic [SIZE_W-1:0]    out_used_reg, out_used_next;
    logic [SIZE_W-1:0]    out_cap_reg, out_cap_next;
    logic                 out_grew_reg, out_grew_next;

    logic [SLOT_W-1:0]    rd_addr;
    logic                 meta_we;
    logic [SLOT_W-1:0]    meta_waddr;
    meta_t                meta_wdata;
    logic                 link_we;
    logic [SLOT_W-1:0]    link_waddr;
    logic [SLOT_W-1:0]    link_wdata;
    meta_t                rd_meta;
    logic [SLOT_W-1:0]    rd_link;
    logic                 clr_busy;

    logic                 in_ready;
    logic [SZ_W-1:0]      sz_sum;
    logic [SZ_W-1:0]      sz;
    logic [HW-1:0]        h_ext;
    logic [SLOT_W-1:0]    h_slot;
    logic                 h_fmt_ok;
    logic [HW-1:0]        blk_end;
    logic [SLOT_W:0]      nx;
    logic [SLOT_W-1:0]    top_slot;
    logic [OVF_W:0]       ovf_sum;
    logic [CW-1:0]        dbl;
    logic                 grew_c;

    sadf_meta_mem #(
        .DEPTH  (NSLOTS),
        .ADDR_W (SLOT_W),
        .META_W (META_W),
        .LINK_W (SLOT_W)
    ) u_meta_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .rd_meta    (rd_meta),
        .rd_link    (rd_link),
        .clr_busy   (clr_busy)
    );

    assign in_ready = (state_reg == ST_IDLE) && !clr_busy;
    assign req.ready = in_ready;

    assign sz_sum   = SZ_W'(reqb_reg) + SZ_W'(HEADER_BYTES) + SZ_W'(7);
    assign sz       = ({sz_sum[SZ_W-1:3], 3'b000} == '0) ? SZ_W'(8)
                                                         : {sz_sum[SZ_W-1:3], 3'b000};
    assign h_ext    = HW'(handle_reg);
    assign h_slot   = SLOT_W'(h_ext >> 3);
    assign h_fmt_ok = (handle_reg[2:0] == 3'b000) && ((h_ext >> 3) < HW'(NSLOTS))
                      && (h_ext < HW'(top_reg));
    assign blk_end  = h_ext + (HW'(rd_meta.length) << 3);
    assign nx       = (SLOT_W + 1)'(h_slot) + (SLOT_W + 1)'(rd_meta.length);
    assign top_slot = SLOT_W'(top_reg >> 3);
    assign ovf_sum  = (OVF_W + 1)'(ovf_reg) + (OVF_W + 1)'(sz);
    assign dbl      = CW'(cap_reg) << 1;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        reqb_next       = reqb_reg;
        handle_next     = handle_reg;
        top_next        = top_reg;
        cap_next        = cap_reg;
        max_next        = max_reg;
        resize_en_next  = resize_en_reg;
        large_next      = large_reg;
        ovf_next        = ovf_reg;
        incr_next       = incr_reg;
        cur_next        = cur_reg;
        lk_next         = lk_reg;
        status_next     = status_reg;
        boff_next       = boff_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_boff_next   = out_boff_reg;
        out_used_next   = out_used_reg;
        out_cap_next    = out_cap_reg;
        out_grew_next   = out_grew_reg;
        rd_addr         = h_slot;
        meta_we         = 1'b0;
        meta_waddr      = h_slot;
        meta_wdata      = '0;
        link_we         = 1'b0;
        link_waddr      = h_slot;
        link_wdata      = h_slot;
        grew_c          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && in_ready)
                begin
                    cmd_next    = req.cmd;
                    reqb_next   = req.req_bytes;
                    handle_next = req.handle;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = STAT_OK;
                boff_next   = '0;
                state_next  = ST_FIN;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (CW'(sz) <= CW'(cap_reg - top_reg))
                    begin
                        meta_we    = 1'b1;
                        meta_waddr = top_slot;
                        meta_wdata = '{live: 1'b1, deleted: 1'b0,
                                       length: LEN_W'(sz >> 3)};
                        link_we    = 1'b1;
                        link_waddr = top_slot;
                        link_wdata = top_slot;
                        boff_next  = HANDLE_W'(top_reg);
                        top_next   = TOP_W'(CW'(top_reg) + CW'(sz));
                    end
                    else
                    begin
                        status_next = STAT_NO_ROOM;
                        if (LARGE_W'(sz) < large_reg)
                        begin
                            ovf_next = ovf_sum[OVF_W] ? OVF_MAX : ovf_sum[OVF_W-1:0];
                        end
                    end
                end
                else if (cmd_reg == CMD_FREE || cmd_reg == CMD_RESIZE)
                begin
                    if (h_fmt_ok)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        status_next = STAT_BAD_HANDLE;
                    end
                end
            end
            ST_CHECK:
            begin
                rd_addr    = rd_link;
                state_next = ST_FIN;
                if (!rd_meta.live)
                begin
                    status_next = STAT_BAD_HANDLE;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    meta_we    = 1'b1;
                    meta_waddr = h_slot;
                    if (blk_end != HW'(top_reg))
                    begin
                        meta_wdata = '{live: 1'b0, deleted: 1'b1, length: rd_meta.length};
                        if (nx < (SLOT_W + 1)'(NSLOTS))
                        begin
                            link_we    = 1'b1;
                            link_waddr = SLOT_W'(nx);
                            link_wdata = h_slot;
                        end
                    end
                    else
                    begin
                        meta_wdata = '{live: 1'b0, deleted: 1'b0, length: rd_meta.length};
                        top_next   = TOP_W'(h_ext);
                        cur_next   = h_slot;
                        lk_next    = rd_link;
                        if (rd_link < h_slot)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
                else if (blk_end != HW'(top_reg))
                begin
                    status_next = STAT_NOT_TOP;
                end
                else if (CW'(sz) > CW'(cap_reg - TOP_W'(h_ext)))
                begin
                    status_next = STAT_NO_ROOM;
                end
                else
                begin
                    meta_we    = 1'b1;
                    meta_waddr = h_slot;
                    meta_wdata = '{live: 1'b1, deleted: 1'b0, length: LEN_W'(sz >> 3)};
                    top_next   = TOP_W'(CW'(h_ext) + CW'(sz));
                end
            end
            ST_WALK:
            begin
                rd_addr    = rd_link;
                state_next = ST_FIN;
                if (rd_meta.deleted && ((SLOT_W + 1)'(lk_reg) + (SLOT_W + 1)'(rd_meta.length)
                                        == (SLOT_W + 1)'(cur_reg)))
                begin
                    meta_we    = 1'b1;
                    meta_waddr = lk_reg;
                    meta_wdata = '{live: 1'b0, deleted: 1'b0, length: rd_meta.length};
                    top_next   = TOP_W'({lk_reg, 3'b000});
                    cur_next   = lk_reg;
                    lk_next    = rd_link;
                    if (rd_link < lk_reg)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    if (cmd_reg == CMD_FREE && status_reg == STAT_OK && top_reg == '0
                        && resize_en_reg)
                    begin
                        if (ovf_reg != '0 && dbl <= CW'(max_reg)
                            && dbl <= CW'(CAPACITY_BYTES))
                        begin
                            cap_next = TOP_W'(dbl);
                            grew_c   = 1'b1;
                            if (incr_reg != CNT_MAX)
                            begin
                                incr_next = incr_reg + 1'b1;
                            end
                        end
                        ovf_next = '0;
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_boff_next   = boff_reg;
                    out_used_next   = SIZE_W'(top_reg);
                    out_cap_next    = SIZE_W'(grew_c ? TOP_W'(dbl) : cap_reg);
                    out_grew_next   = grew_c;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_SIZE:
                begin
                    if (top_reg == '0)
                    begin
                        cap_next = clamp_cap(cfg_data[SIZE_W-1:0]);
                    end
                end
                CFG_MAX_SIZE:  max_next       = cfg_data[SIZE_W-1:0];
                CFG_RESIZE_EN: resize_en_next = cfg_data[0];
                CFG_LARGE:     large_next     = cfg_data[LARGE_W-1:0];
                default:       max_next       = max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            cap_reg       <= CAP_RESET;
            max_reg       <= MAX_RESET;
            resize_en_reg <= 1'b1;
            large_reg     <= LARGE_RESET;
            ovf_reg       <= '0;
            incr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cap_reg       <= cap_next;
            max_reg       <= max_next;
            resize_en_reg <= resize_en_next;
            large_reg     <= large_next;
            ovf_reg       <= ovf_next;
            incr_reg      <= incr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        reqb_reg       <= reqb_next;
        handle_reg     <= handle_next;
        cur_reg        <= cur_next;
        lk_reg         <= lk_next;
        status_reg     <= status_next;
        boff_reg       <= boff_next;
        out_status_reg <= out_status_next;
        out_boff_reg   <= out_boff_next;
        out_used_reg   <= out_used_next;
        out_cap_reg    <= out_cap_next;
        out_grew_reg   <= out_grew_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.block_offset   = out_boff_reg;
    assign rsp.used_bytes     = out_used_reg;
    assign rsp.capacity_bytes = out_cap_reg;
    assign rsp.grew           = out_grew_reg;

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !req.ready)
        else $error("request taken during the mark clearing pass");

    a_top_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= cap_reg)
        else $error("top pointer beyond active capacity");

    a_walk_only_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> cmd_reg == CMD_FREE)
        else $error("rollback walk outside a free");

    a_growth_counted_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(incr_reg) |-> $past(state_reg == ST_FIN) && out_grew_reg)
        else $error("growth count changed without a growth result");

    a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.block_offset[2:0] == 3'b000)
        else $error("block offset not on an 8-byte boundary");

endmodule
